// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the activation function unit
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define AFU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define AFU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/afu_pkg.sv =====
// ----------------------------------------------------------------------------
// afu_pkg
// shared types, constants and the sigmoid table of the activation unit
// ----------------------------------------------------------------------------
`default_nettype none

package afu_pkg;

    localparam int FRAC_BITS     = 12;
    localparam int TABLE_ENTRIES = 64;
    localparam int DATA_W        = 16;
    localparam int SLOPE_W       = 16;
    localparam int FUNC_W        = 3;
    // unsigned Q16 values in 0 .. 1.0 inclusive
    localparam int Q16_W         = 17;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES + 1);
    localparam int POS_W         = 16 + IDX_W;
    localparam int DEF_QUEUE_DEPTH = 4;

    localparam logic [SLOPE_W-1:0] LEAK_SLOPE_RST = 16'd655;

    localparam logic [63:0] Q30_ONE  = 64'd1 << 30;
    localparam logic [63:0] Q30_HALF = 64'd1 << 29;

    typedef enum logic [FUNC_W-1:0] {
        FN_RELU      = 3'd0,
        FN_RELU_D    = 3'd1,
        FN_LEAKY     = 3'd2,
        FN_LEAKY_D   = 3'd3,
        FN_SIGMOID   = 3'd4,
        FN_SIGMOID_D = 3'd5,
        FN_TANH      = 3'd6,
        FN_TANH_D    = 3'd7
    } t_func;

    // classified sample handed from the front end to the back end
    typedef struct packed {
        t_func                    func;
        logic signed [DATA_W-1:0] x;
        logic                     is_neg;
        logic                     is_pos;
        logic [IDX_W-1:0]         idx;
        logic [15:0]              frac;
        logic                     clamp;
    } t_item;

    typedef logic [TABLE_ENTRIES:0][Q16_W-1:0] t_rom;

    // restoring division, only evaluated while building the table
    function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] rem;
        q   = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem  = rem - {1'b0, den};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // sigmoid samples at i * 2^(16-FRAC_BITS) / TABLE_ENTRIES, unsigned Q16
    function automatic t_rom build_rom();
        logic [63:0]        g;
        logic [63:0]        term;
        logic [63:0]        r;
        logic [63:0]        e;
        logic [63:0]        d;
        logic signed [63:0] sum;
        t_rom               rom;
        rom  = '0;
        g    = div_u64((64'd1 << 27) + 64'(TABLE_ENTRIES / 2), 64'(TABLE_ENTRIES));
        term = Q30_ONE;
        sum  = $signed(Q30_ONE);
        // e^-g by taylor series in Q30
        for (int k = 1; k <= 16; k++) begin
            if (term != '0) begin
                term = (term * g + Q30_HALF) >> 30;
                term = div_u64(term + (64'(k) >> 1), 64'(k));
                if (k[0]) begin
                    sum = sum - $signed(term);
                end else begin
                    sum = sum + $signed(term);
                end
            end
        end
        if (sum < 0) begin
            r = '0;
        end else begin
            r = $unsigned(sum);
        end
        if (r > Q30_ONE) begin
            r = Q30_ONE;
        end
        for (int k = 0; k < 19 - FRAC_BITS; k++) begin
            r = (r * r + Q30_HALF) >> 30;
        end
        e = Q30_ONE;
        for (int k = 0; k <= TABLE_ENTRIES; k++) begin
            d      = Q30_ONE + e;
            rom[k] = Q16_W'(div_u64((64'd1 << 46) + (d >> 1), d));
            e      = (e * r + Q30_HALF) >> 30;
        end
        return rom;
    endfunction

    localparam t_rom SIG_ROM = build_rom();

endpackage

`default_nettype wire

// ===== rtl/activation_function_unit.sv =====
// a sample passes the front register, the queue, the back end stages and the output register
// throughput: one transaction per cycle, sustained, on both channels while the receiver does not stall
// the sigmoid table is constant logic, so no fill or clearing pass is needed
// reset (i_rst_n low, synchronous) empties front register, queue and pipeline
// and sets leak_slope to 655 (about 0.01 in unsigned Q0.16)
// ----------------------------------------------------------------------------
// activation_function_unit
// relu, leaky relu, sigmoid and tanh with derivatives on Q4.12 samples
// ----------------------------------------------------------------------------
`default_nettype none

module activation_function_unit #(
    parameter int QUEUE_DEPTH = afu_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // sample channel
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [afu_pkg::FUNC_W-1:0]        i_func,
    input  logic signed [afu_pkg::DATA_W-1:0] i_x_value,
    // result channel
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [afu_pkg::DATA_W-1:0] o_y_value,
    // leak_slope register write
    input  logic                              i_cfg_we,
    input  logic [afu_pkg::SLOPE_W-1:0]       i_cfg_wdata
);
    import afu_pkg::*;

    // front end: register one transaction, decode the function code and
    // work out the table index and fraction for sigmoid and tanh
    // queue: absorbs a stalled back end so the input keeps flowing
    // back end: stage 1 table read and shared multiplier (x*slope or x*x),
    // stage 2 interpolation and saturated direct results, stage 3 sign
    // fold and s*(1-s), then rounding into the output register

    logic [SLOPE_W-1:0] r_leak_slope;
    t_item              front_item;
    logic               front_push;
    logic               q_full;
    logic               q_valid;
    t_item              q_item;
    logic               q_pop;

    // the user writes config only while the unit is idle; the block does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_leak_slope <= LEAK_SLOPE_RST;
        end else if (i_cfg_we) begin
            r_leak_slope <= i_cfg_wdata;
        end
    end

    afu_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_func    (i_func),
        .i_x_value (i_x_value),
        .o_item    (front_item),
        .o_push    (front_push),
        .i_full    (q_full)
    );

    afu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (front_push),
        .i_push_item (front_item),
        .o_full      (q_full),
        .o_valid     (q_valid),
        .o_item      (q_item),
        .i_pop       (q_pop)
    );

    afu_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (q_item),
        .i_item_valid (q_valid),
        .o_pop        (q_pop),
        .i_leak_slope (r_leak_slope),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_y_value    (o_y_value)
    );

endmodule

`default_nettype wire

// ===== rtl/afu_front.sv =====
// ----------------------------------------------------------------------------
// afu_front
// accepts samples, decodes the function and computes the table position
// ----------------------------------------------------------------------------
`default_nettype none

module afu_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [afu_pkg::FUNC_W-1:0]        i_func,
    input  logic signed [afu_pkg::DATA_W-1:0] i_x_value,
    output afu_pkg::t_item                    o_item,
    output logic                              o_push,
    input  logic                              i_full
);
    import afu_pkg::*;

    logic                    r_valid;
    logic                    n_valid;
    t_item                   r_item;
    t_item                   n_item;
    logic                    accept;
    logic signed [Q16_W-1:0] x_ext;
    logic [Q16_W-1:0]        mag;
    logic [Q16_W-1:0]        lut_arg;
    logic [POS_W-1:0]        pos;
    logic [IDX_W-1:0]        idx_raw;

    assign o_stall = r_valid & i_full;
    assign o_push  = r_valid & ~i_full;
    assign accept  = i_valid & ~o_stall;
    assign o_item  = r_item;

    always_comb begin
        x_ext   = Q16_W'(i_x_value);
        mag     = i_x_value[DATA_W-1] ? $unsigned(-x_ext) : $unsigned(x_ext);
        // tanh looks up sigmoid at twice the magnitude
        lut_arg = (t_func'(i_func) == FN_TANH) ? (mag << 1) : mag;
        pos     = POS_W'(lut_arg) * POS_W'(TABLE_ENTRIES);
        idx_raw = pos[POS_W-1:16];

        n_item.func   = t_func'(i_func);
        n_item.x      = i_x_value;
        n_item.is_neg = i_x_value[DATA_W-1];
        n_item.is_pos = ~i_x_value[DATA_W-1] & (i_x_value != '0);
        n_item.idx    = idx_raw;
        n_item.frac   = pos[15:0];
        n_item.clamp  = idx_raw >= IDX_W'(TABLE_ENTRIES);
    end

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/afu_queue.sv =====
// ----------------------------------------------------------------------------
// afu_queue
// small fifo of classified samples between front end and back end
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module afu_queue #(
    parameter int DEPTH = afu_pkg::DEF_QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  afu_pkg::t_item i_push_item,
    output logic           o_full,
    output logic           o_valid,
    output afu_pkg::t_item o_item,
    input  logic           i_pop
);
    import afu_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    assign o_full  = r_count == CNT_W'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

    `AFU_ASSERT_NOW(a_cnt_max, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(DEPTH), "queue count beyond depth")
    `AFU_ASSERT_NOW(a_no_over, i_clk, i_rst_n, i_push, !o_full, "push into full queue")
    `AFU_ASSERT_NOW(a_no_under, i_clk, i_rst_n, i_pop, o_valid, "pop from empty queue")
    `AFU_ASSERT_NEXT(a_cnt_up, i_clk, i_rst_n, i_push && !i_pop, r_count == $past(r_count) + 1'b1, "count missed a push")

endmodule

`default_nettype wire

// ===== rtl/afu_back.sv =====
// ----------------------------------------------------------------------------
// afu_back
// table lookup, interpolation, multiply, rounding and saturation pipeline
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module afu_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  afu_pkg::t_item                     i_item,
    input  logic                               i_item_valid,
    output logic                               o_pop,
    input  logic [afu_pkg::SLOPE_W-1:0]        i_leak_slope,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [afu_pkg::DATA_W-1:0]  o_y_value
);
    import afu_pkg::*;

    localparam int OP_W    = DATA_W + 1;
    localparam int MUL_W   = 2 * OP_W;
    localparam int SAT_W   = MUL_W + 2;
    localparam int IP_W    = Q16_W + 17;
    localparam int SR_W    = Q16_W + 1;
    localparam int DP_W    = 2 * Q16_W;
    localparam int RND_SH  = 16 - FRAC_BITS;
    localparam int RND_Q16 = 1 << (RND_SH - 1);
    localparam int DRV_SH  = 32 - FRAC_BITS;
    localparam int DRV_RND = 1 << (DRV_SH - 1);

    localparam logic [Q16_W-1:0]        Q16_ONE = Q16_W'(1 << 16);
    localparam logic signed [SAT_W-1:0] ONE_Q   = SAT_W'(1 << FRAC_BITS);
    localparam logic signed [SAT_W-1:0] ONE_SQ  = SAT_W'(1 << (2 * FRAC_BITS));
    localparam logic signed [SAT_W-1:0] HALF_F  = SAT_W'(1 << (FRAC_BITS - 1));
    localparam logic signed [SAT_W-1:0] HALF_16 = SAT_W'(1 << 15);
    localparam logic signed [SAT_W-1:0] S_ZERO  = SAT_W'(0);
    localparam logic signed [SAT_W-1:0] Y_MAX   = SAT_W'((1 << (DATA_W - 1)) - 1);
    localparam logic signed [SAT_W-1:0] Y_MIN   = SAT_W'(-(1 << (DATA_W - 1)));

    function automatic logic signed [DATA_W-1:0] sat16(input logic signed [SAT_W-1:0] v);
        if (v > Y_MAX) begin
            return DATA_W'(Y_MAX);
        end else if (v < Y_MIN) begin
            return DATA_W'(Y_MIN);
        end
        return DATA_W'(v);
    endfunction

    logic adv;

    // stage 1: table read and shared multiplier
    logic [IDX_W-1:0]         a_idx;
    logic [IDX_W-1:0]         b_idx;
    logic signed [OP_W-1:0]   mul_a;
    logic signed [OP_W-1:0]   mul_b;
    logic [Q16_W-1:0]         n_s1_a;
    logic [Q16_W-1:0]         n_s1_diff;
    logic signed [MUL_W-1:0]  n_s1_prod;
    logic                     r_s1_valid;
    t_func                    r_s1_func;
    logic                     r_s1_neg;
    logic                     r_s1_pos;
    logic signed [DATA_W-1:0] r_s1_x;
    logic [15:0]              r_s1_frac;
    logic [Q16_W-1:0]         r_s1_a;
    logic [Q16_W-1:0]         r_s1_diff;
    logic signed [MUL_W-1:0]  r_s1_prod;

    // stage 2: interpolation and direct results
    logic [IP_W-1:0]          ip;
    logic signed [SAT_W-1:0]  prod_ext;
    logic signed [SAT_W-1:0]  x_ext;
    logic [SLOPE_W:0]         slope_rnd;
    logic signed [SAT_W-1:0]  dv;
    logic [Q16_W-1:0]         n_s2_sig;
    logic signed [DATA_W-1:0] n_s2_ydir;
    logic                     r_s2_valid;
    t_func                    r_s2_func;
    logic                     r_s2_neg;
    logic [Q16_W-1:0]         r_s2_sig;
    logic signed [DATA_W-1:0] r_s2_ydir;

    // stage 3: sign fold and derivative product
    logic [Q16_W-1:0]         om;
    logic [Q16_W-1:0]         n_s3_sn;
    logic [DP_W-1:0]          n_s3_dprod;
    logic                     r_s3_valid;
    t_func                    r_s3_func;
    logic                     r_s3_neg;
    logic [Q16_W-1:0]         r_s3_sn;
    logic [DP_W-1:0]          r_s3_dprod;
    logic signed [DATA_W-1:0] r_s3_ydir;

    // output register
    logic [SR_W-1:0]          rq;
    logic [SR_W-1:0]          tv;
    logic [SR_W-1:0]          tq;
    logic [DP_W-1:0]          dq;
    logic signed [DATA_W-1:0] tmag;
    logic signed [DATA_W-1:0] n_y_value;
    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_y_value;

    assign adv       = ~r_out_valid | ~i_stall;
    assign o_pop     = adv & i_item_valid;
    assign o_valid   = r_out_valid;
    assign o_y_value = r_y_value;

    always_comb begin
        a_idx     = i_item.clamp ? IDX_W'(TABLE_ENTRIES) : i_item.idx;
        b_idx     = i_item.clamp ? IDX_W'(TABLE_ENTRIES) : i_item.idx + 1'b1;
        n_s1_a    = SIG_ROM[a_idx];
        n_s1_diff = SIG_ROM[b_idx] - SIG_ROM[a_idx];
        mul_a     = OP_W'($signed(i_item.x));
        mul_b     = (i_item.func == FN_LEAKY) ? $signed({1'b0, i_leak_slope}) : mul_a;
        n_s1_prod = MUL_W'(mul_a) * MUL_W'(mul_b);
    end

    always_comb begin
        ip        = IP_W'(r_s1_diff) * IP_W'(r_s1_frac) + IP_W'(1 << 15);
        n_s2_sig  = r_s1_a + ip[Q16_W+15:16];
        prod_ext  = SAT_W'(r_s1_prod);
        x_ext     = SAT_W'(r_s1_x);
        slope_rnd = {1'b0, i_leak_slope} + (SLOPE_W + 1)'(RND_Q16);
        case (r_s1_func)
            FN_RELU: begin
                dv = r_s1_pos ? x_ext : S_ZERO;
            end
            FN_RELU_D: begin
                dv = r_s1_pos ? ONE_Q : S_ZERO;
            end
            FN_LEAKY: begin
                dv = r_s1_pos ? x_ext : ((prod_ext + HALF_16) >>> 16);
            end
            FN_LEAKY_D: begin
                dv = r_s1_pos ? ONE_Q : $signed(SAT_W'(slope_rnd >> RND_SH));
            end
            FN_TANH_D: begin
                // 1 - x*x with x already a tanh output
                dv = (ONE_SQ - prod_ext + HALF_F) >>> FRAC_BITS;
            end
            default: begin
                dv = S_ZERO;
            end
        endcase
        n_s2_ydir = sat16(dv);
    end

    always_comb begin
        n_s3_sn = r_s2_sig;
        if (r_s2_neg && (r_s2_func == FN_SIGMOID || r_s2_func == FN_SIGMOID_D)) begin
            n_s3_sn = Q16_ONE - r_s2_sig;
        end
        om         = Q16_ONE - n_s3_sn;
        n_s3_dprod = DP_W'(n_s3_sn) * DP_W'(om);
    end

    always_comb begin
        rq   = {1'b0, r_s3_sn} + SR_W'(RND_Q16);
        // 2s - 1, never negative since the lookup is at least one half
        tv   = {r_s3_sn, 1'b0} - SR_W'(1 << 16);
        tq   = tv + SR_W'(RND_Q16);
        dq   = r_s3_dprod + DP_W'(DRV_RND);
        tmag = DATA_W'(tq >> RND_SH);
        case (r_s3_func)
            FN_SIGMOID: begin
                n_y_value = DATA_W'(rq >> RND_SH);
            end
            FN_SIGMOID_D: begin
                n_y_value = DATA_W'(dq >> DRV_SH);
            end
            FN_TANH: begin
                n_y_value = r_s3_neg ? -tmag : tmag;
            end
            default: begin
                n_y_value = r_s3_ydir;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid  <= i_item_valid;
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid;
            r_out_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_func  <= i_item.func;
            r_s1_neg   <= i_item.is_neg;
            r_s1_pos   <= i_item.is_pos;
            r_s1_x     <= i_item.x;
            r_s1_frac  <= i_item.frac;
            r_s1_a     <= n_s1_a;
            r_s1_diff  <= n_s1_diff;
            r_s1_prod  <= n_s1_prod;
            r_s2_func  <= r_s1_func;
            r_s2_neg   <= r_s1_neg;
            r_s2_sig   <= n_s2_sig;
            r_s2_ydir  <= n_s2_ydir;
            r_s3_func  <= r_s2_func;
            r_s3_neg   <= r_s2_neg;
            r_s3_sn    <= n_s3_sn;
            r_s3_dprod <= n_s3_dprod;
            r_s3_ydir  <= r_s2_ydir;
            r_y_value  <= n_y_value;
        end
    end

    `AFU_ASSERT_NEXT(a_hold, i_clk, i_rst_n, r_out_valid && i_stall, $stable(r_s1_valid) && $stable(r_s2_valid) && $stable(r_s3_valid), "pipeline moved under stall")
    `AFU_ASSERT_NEXT(a_pop_load, i_clk, i_rst_n, o_pop, r_s1_valid, "popped sample not in stage one")
    `AFU_ASSERT_NEXT(a_drain, i_clk, i_rst_n, !r_out_valid && r_s3_valid, r_out_valid, "result not moved to output")

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the activation function unit: every accepted
// sample is scored against a local fixed-point model of all eight functions,
// across several leak slopes and sender and receiver idle patterns
// ----------------------------------------------------------------------------

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import afu_pkg::*;

    // leave some margin when draining the pipeline
    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_ITEMS  = 190;
    localparam longint unsigned Q30 = 64'd1 << 30;
    localparam longint ONE_Q = longint'(1) << FRAC_BITS;

    typedef struct {
        t_func                    func;
        logic signed [DATA_W-1:0] x;
    } t_sample;

    typedef struct {
        t_func                    func;
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
    } t_result;

    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       i_valid     = 1'b0;
    logic                       o_stall;
    logic [FUNC_W-1:0]          i_func      = '0;
    logic signed [DATA_W-1:0]   i_x_value   = '0;
    logic                       o_valid;
    logic                       i_stall     = 1'b0;
    logic signed [DATA_W-1:0]   o_y_value;
    logic                       i_cfg_we    = 1'b0;
    logic [SLOPE_W-1:0]         i_cfg_wdata = '0;

    // samples waiting to be driven, and results waiting to come out
    t_sample sample_queue[$];
    t_result pending_y[$];

    // sigmoid samples in unsigned Q16, built locally with integer math
    longint unsigned sig_table[TABLE_ENTRIES+1];

    // local copy of the leak slope register
    logic [SLOPE_W-1:0] leak_model = LEAK_SLOPE_RST;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int n_fail         = 0;
    int cycle_count    = 0;

    t_sample next_smp;
    t_result want;

    activation_function_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_func      (i_func),
        .i_x_value   (i_x_value),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_y_value   (o_y_value),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // 4 ns period
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // interpolated sigmoid at a nonnegative Q.FRAC_BITS position, Q16 result
    function automatic longint unsigned sigmoid_at(longint unsigned t);
        longint unsigned pos;
        longint unsigned idx;
        longint          frac;
        longint          a;
        longint          b;
        longint          acc;
        pos  = t * TABLE_ENTRIES;
        idx  = pos >> 16;
        frac = longint'(pos & 64'hFFFF);
        // past the table span the last entry holds
        if (idx >= TABLE_ENTRIES) begin
            return sig_table[TABLE_ENTRIES];
        end
        a   = longint'(sig_table[idx]);
        b   = longint'(sig_table[idx+1]);
        acc = a * 65536 + (b - a) * frac + 32768;
        return longint'(acc >>> 16);
    endfunction

    // activation result of one sample under the given leak slope
    function automatic logic signed [DATA_W-1:0] activation_of(
        t_func fn, logic signed [DATA_W-1:0] xv, logic [SLOPE_W-1:0] slope
    );
        longint          x;
        longint          mag;
        longint          k;
        longint          y;
        longint unsigned s;
        longint unsigned v;
        x   = longint'(xv);
        k   = longint'(slope);
        mag = (x < 0) ? -x : x;
        y   = 0;
        case (fn)
            FN_RELU: begin
                y = (x > 0) ? x : 0;
            end
            FN_RELU_D: begin
                y = (x > 0) ? ONE_Q : 0;
            end
            FN_LEAKY: begin
                // zero falls on the negative side, floor of x*slope + half
                y = (x > 0) ? x : ((x * k + 32768) >>> 16);
            end
            FN_LEAKY_D: begin
                y = (x > 0) ? ONE_Q : ((k + (1 << (15 - FRAC_BITS))) >> (16 - FRAC_BITS));
            end
            FN_SIGMOID, FN_SIGMOID_D: begin
                s = sigmoid_at(mag);
                if (x < 0) begin
                    s = 65536 - s;
                end
                if (fn == FN_SIGMOID) begin
                    y = longint'((s + (1 << (15 - FRAC_BITS))) >> (16 - FRAC_BITS));
                end else begin
                    // s*(1-s) is Q32
                    v = s * (65536 - s);
                    y = longint'((v + (1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS));
                end
            end
            FN_TANH: begin
                // tanh = 2*sigmoid(2x) - 1, rounded on the magnitude
                v = sigmoid_at(2 * mag) * 2 - 65536;
                y = longint'((v + (1 << (15 - FRAC_BITS))) >> (16 - FRAC_BITS));
                if (x < 0) begin
                    y = -y;
                end
            end
            default: begin
                // x is taken as a tanh output already
                y = (ONE_Q * ONE_Q - x * x + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
            end
        endcase
        if (y > 32767) begin
            y = 32767;
        end else if (y < -32768) begin
            y = -32768;
        end
        return DATA_W'(y);
    endfunction

    // sample channel driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            // transaction accepted at this edge: record what must come out
            if (i_valid && !o_stall) begin
                pending_y.push_back('{t_func'(i_func), i_x_value,
                                      activation_of(t_func'(i_func), i_x_value, leak_model)});
            end
            // payload only moves when nothing is held
            if (!i_valid || !o_stall) begin
                if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_smp = sample_queue.pop_front();
                    i_valid   <= 1'b1;
                    i_func    <= next_smp.func;
                    i_x_value <= next_smp.x;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // result channel monitor and stall generator
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (pending_y.size() == 0) begin
                    n_fail++;
                    if (n_fail <= 10) begin
                        $display("unexpected result: y=%0d", o_y_value);
                    end
                end else begin
                    want = pending_y.pop_front();
                    if (o_y_value !== want.y) begin
                        n_fail++;
                        if (n_fail <= 10) begin
                            $display("mismatch: func=%s x=%0d expected y=%0d actual y=%0d",
                                     want.func.name(), want.x, want.y, o_y_value);
                        end
                    end
                end
            end
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // blocks until every queued sample has been taken by the unit, checked
    // on the falling edge once the driver's rising edge updates have settled
    task automatic wait_sent();
        @(negedge i_clk);
        while (sample_queue.size() != 0 || i_valid) begin
            @(negedge i_clk);
        end
    endtask

    // leak slope write, only once the unit has fully drained
    task automatic write_leak_slope(logic [SLOPE_W-1:0] value);
        wait_sent();
        while (pending_y.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        leak_model   = value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // one phase of random samples under a given idle pattern
    task automatic run_phase(int n, int idle_pct, int stall_pct);
        t_sample smp;
        int      pick;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < n; i++) begin
            pick     = $urandom_range(7);
            smp.func = t_func'($urandom_range(7));
            case (pick)
                0, 1: begin
                    // around zero, where the functions bend
                    smp.x = DATA_W'($urandom_range(8192) - 4096);
                end
                2: begin
                    // near both ends of the range, saturation territory
                    if ($urandom_range(1)) begin
                        smp.x = DATA_W'(16'sh7fff - $urandom_range(3));
                    end else begin
                        smp.x = DATA_W'(16'sh8000 + $urandom_range(3));
                    end
                end
                default: begin
                    smp.x = DATA_W'($urandom);
                end
            endcase
            sample_queue.push_back(smp);
        end
        wait_sent();
    endtask

    initial begin
        longint unsigned g;
        longint unsigned term;
        longint unsigned ratio;
        longint unsigned e;
        longint unsigned d;
        longint          taylor;
        t_sample         smp;

        // sigmoid table: e^-g by taylor series in Q30, then raised to the step
        g      = ((64'd1 << 27) + TABLE_ENTRIES / 2) / TABLE_ENTRIES;
        term   = Q30;
        taylor = longint'(Q30);
        for (int k = 1; k <= 16; k++) begin
            if (term != 0) begin
                term = (term * g + Q30 / 2) >> 30;
                term = (term + 64'(k / 2)) / 64'(k);
                if (k % 2 == 1) begin
                    taylor = taylor - longint'(term);
                end else begin
                    taylor = taylor + longint'(term);
                end
            end
        end
        ratio = (taylor < 0) ? 0 : longint'(taylor);
        if (ratio > Q30) begin
            ratio = Q30;
        end
        for (int k = 0; k < 19 - FRAC_BITS; k++) begin
            ratio = (ratio * ratio + Q30 / 2) >> 30;
        end
        e = Q30;
        for (int k = 0; k <= TABLE_ENTRIES; k++) begin
            d            = Q30 + e;
            sig_table[k] = ((64'd1 << 46) + d / 2) / d;
            e            = (e * ratio + Q30 / 2) >> 30;
        end

        // reset, held low from the start and then released
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: every function at zero and at both range ends
        for (int f = 0; f < 8; f++) begin
            smp.func = t_func'(f);
            smp.x    = 16'sh0000;
            sample_queue.push_back(smp);
            smp.x    = 16'sh7fff;
            sample_queue.push_back(smp);
            smp.x    = 16'sh8000;
            sample_queue.push_back(smp);
        end
        // smallest negative step through the leak slope
        smp.func = FN_LEAKY;
        smp.x    = -16'sd1;
        sample_queue.push_back(smp);
        wait_sent();

        // random phases, reset slope first, then the extremes and a few more
        run_phase(PHASE_ITEMS, 0, 0);
        write_leak_slope(16'h0000);
        run_phase(PHASE_ITEMS, 82, 0);
        write_leak_slope(16'hffff);
        run_phase(PHASE_ITEMS, 0, 82);
        write_leak_slope(16'h0001);
        run_phase(PHASE_ITEMS, 34, 34);
        write_leak_slope(16'h8000);
        run_phase(PHASE_ITEMS, 0, 0);
        write_leak_slope(16'($urandom));
        run_phase(PHASE_ITEMS, 82, 82);
        write_leak_slope(16'($urandom));
        run_phase(PHASE_ITEMS, 34, 34);

        // drain, then give stray results a chance to show up
        while (pending_y.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES * 4) @(posedge i_clk);

        if (n_fail == 0 && pending_y.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
